/* src/vmeg_pkg.sv */
// vmeg_pkg: shared types and constants of the voice mixer with envelope and lfo gain
// used by the lane modules, the mixer, the top level and the checker
`timescale 1ns / 1ps
`default_nettype none

package vmeg_pkg;

  localparam int unsigned VoiceCount = 4;
  localparam int unsigned SampleW    = 16;
  localparam int unsigned LevelW     = 16;
  localparam int unsigned SumW       = SampleW + $clog2(VoiceCount);
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [LevelW-1:0] Unity = 16'h8000;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgEnvAmount = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgLfoAmount = 1'd1;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [LevelW-1:0]         level_t;

  typedef struct packed {
    sample_t voice_a;
    sample_t voice_b;
    sample_t voice_c;
    sample_t voice_d;
    level_t  env_a;
    level_t  env_b;
    level_t  env_c;
    level_t  env_d;
    level_t  lfo_level;
    logic    block_start;
  } frame_beat_t;

  typedef struct packed {
    sample_t mix_sample;
  } mix_beat_t;

  function automatic level_t clamp_unity(input level_t x);
    clamp_unity = (x > Unity) ? Unity : x;
  endfunction

endpackage

`default_nettype wire

/* src/vmeg_stream_if.sv */
// vmeg_stream_if: valid/ready channel carrying one payload beat
// payload type is set at instantiation from vmeg_pkg types
`timescale 1ns / 1ps
`default_nettype none

interface vmeg_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* src/vmeg_gain_lane.sv */
// vmeg_gain_lane: modulation gain 1 - (1 - level) * amount in q1.15
// depends on vmeg_pkg for the level type and clamping
`timescale 1ns / 1ps
`default_nettype none

module vmeg_gain_lane
  import vmeg_pkg::*;
(
  input  level_t level_i,
  input  level_t amount_i,
  output level_t gain_o
);

  level_t      depth;
  level_t      amt;
  logic [31:0] prod;

  always_comb begin
    depth  = Unity - clamp_unity(level_i);
    amt    = clamp_unity(amount_i);
    prod   = 32'(depth) * 32'(amt);
    gain_o = Unity - prod[30:15];
  end

endmodule

`default_nettype wire

/* src/vmeg_voice_lane.sv */
// vmeg_voice_lane: scales one voice by its gain and holds the result
// a zero sample keeps the held value unless clear_i is set; depends on vmeg_pkg
`timescale 1ns / 1ps
`default_nettype none

module vmeg_voice_lane
  import vmeg_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    clear_i,
  input  sample_t voice_i,
  input  level_t  gain_i,
  output sample_t held_o
);

  logic signed [32:0] prod;
  logic signed [32:0] biased;
  logic signed [32:0] shifted;
  sample_t            held_d;
  sample_t            held_q;

  always_comb begin
    prod    = voice_i * $signed({1'b0, gain_i});
    // truncate toward zero
    biased  = prod + (prod[32] ? 33'sd32767 : 33'sd0);
    shifted = biased >>> 15;
    if (voice_i != '0) begin
      held_d = shifted[SampleW-1:0];
    end else if (clear_i) begin
      held_d = '0;
    end else begin
      held_d = held_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (en_i) begin
      held_q <= held_d;
    end
  end

  assign held_o = held_q;

endmodule

`default_nettype wire

/* src/vmeg_mix.sv */
// vmeg_mix: sums the held lane values, applies the tremolo gain, saturates
// depends on vmeg_pkg for widths and types
`timescale 1ns / 1ps
`default_nettype none

module vmeg_mix
  import vmeg_pkg::*;
(
  input  sample_t held_i [VoiceCount],
  input  level_t  trem_gain_i,
  output sample_t mix_o
);

  localparam int unsigned ProdW = SumW + LevelW + 1;

  logic signed [SumW-1:0]  sum;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] biased;
  logic signed [ProdW-1:0] scaled;

  always_comb begin
    sum = '0;
    for (int v = 0; v < VoiceCount; v++) begin
      sum = sum + SumW'(held_i[v]);
    end
    prod   = ProdW'(sum) * $signed({1'b0, trem_gain_i});
    biased = prod + (prod[ProdW-1] ? ProdW'(32767) : ProdW'(0));
    scaled = biased >>> 15;
    if (scaled > ProdW'(32767)) begin
      mix_o = 16'sh7fff;
    end else if (scaled < -ProdW'(32768)) begin
      mix_o = -16'sh8000;
    end else begin
      mix_o = scaled[SampleW-1:0];
    end
  end

endmodule

`default_nettype wire

/* src/voice_mixer_envelope_gain.sv */
// voice_mixer_envelope_gain: four-voice mixer with envelope and lfo amplitude modulation
// depends on vmeg_pkg, vmeg_stream_if, vmeg_gain_lane, vmeg_voice_lane, vmeg_mix
//
// frame_i takes one frame beat (four samples, four envelope levels, lfo level,
// block start); mix_o gives one mixed sample beat for each frame.
// cfg_we_i/cfg_index_i/cfg_data_i write the envelope and lfo modulation
// amounts; write them only while no frame is in flight.
// a frame goes through gain update, lane scaling and mixing (ST_GAIN, ST_SCALE,
// ST_MIX): the result is loaded into the output register as the sequencer
// leaves ST_MIX, and frame_i.ready returns at that same edge, so the next
// frame cannot be taken before then; one frame is in flight at a time.
// the per-frame state (gains, held lane values, update phase) sets this limit.
// the output register lets the next frame be taken while a result waits; a
// stalled receiver then holds that frame in the mixing step until the
// output register frees up.
// reset sets all gains to 1.0, clears the held values, the update phase and
// both amounts; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module voice_mixer_envelope_gain
  import vmeg_pkg::*;
#(
  parameter int unsigned UPDATE_LAST_PHASE = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  vmeg_stream_if.sink         frame_i,
  vmeg_stream_if.source       mix_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned PhaseW =
    (UPDATE_LAST_PHASE > 0) ? $clog2(UPDATE_LAST_PHASE + 1) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GAIN,
    ST_SCALE,
    ST_MIX
  } state_e;

  state_e      state_q;
  logic        out_valid_q;
  mix_beat_t   out_q;
  frame_beat_t frame_q;

  level_t env_amount_q;
  level_t lfo_amount_q;

  level_t             voice_gain_q [VoiceCount];
  level_t             voice_gain_d [VoiceCount];
  level_t             gain_new     [VoiceCount];
  level_t             env_level    [VoiceCount];
  sample_t            voice_in     [VoiceCount];
  sample_t            held         [VoiceCount];
  level_t             trem_gain_q;
  level_t             trem_gain_d;
  level_t             trem_new;
  logic [PhaseW-1:0]  phase_q;
  logic [PhaseW-1:0]  phase_eff;
  logic [PhaseW-1:0]  phase_d;
  logic               recompute;
  logic               out_free;
  sample_t            mix_value;

  assign frame_i.ready = (state_q == ST_IDLE);
  assign mix_o.valid   = out_valid_q;
  assign mix_o.payload = out_q;
  assign out_free      = !out_valid_q || mix_o.ready;

  assign voice_in  = '{frame_q.voice_a, frame_q.voice_b, frame_q.voice_c, frame_q.voice_d};
  assign env_level = '{frame_q.env_a, frame_q.env_b, frame_q.env_c, frame_q.env_d};

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_amount_q <= '0;
      lfo_amount_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgEnvAmount: env_amount_q <= cfg_data_i;
        CfgLfoAmount: lfo_amount_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // frame capture
  always_ff @(posedge clk_i) begin
    if (frame_i.valid && frame_i.ready) begin
      frame_q <= frame_i.payload;
    end
  end

  // gain lanes
  for (genvar v = 0; v < VoiceCount; v++) begin : g_gain
    vmeg_gain_lane u_gain (
      .level_i  (env_level[v]),
      .amount_i (env_amount_q),
      .gain_o   (gain_new[v])
    );
  end

  vmeg_gain_lane u_trem_gain (
    .level_i  (frame_q.lfo_level),
    .amount_i (lfo_amount_q),
    .gain_o   (trem_new)
  );

  always_comb begin
    phase_eff = frame_q.block_start ? '0 : phase_q;
    recompute = (phase_eff == '0) && (env_amount_q != '0 || lfo_amount_q != '0);
    phase_d   = (phase_eff >= PhaseW'(UPDATE_LAST_PHASE)) ? '0 : phase_eff + PhaseW'(1);
    for (int v = 0; v < VoiceCount; v++) begin
      if (recompute) begin
        voice_gain_d[v] = gain_new[v];
      end else if (frame_q.block_start) begin
        voice_gain_d[v] = Unity;
      end else begin
        voice_gain_d[v] = voice_gain_q[v];
      end
    end
    if (recompute) begin
      trem_gain_d = trem_new;
    end else if (frame_q.block_start) begin
      trem_gain_d = Unity;
    end else begin
      trem_gain_d = trem_gain_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < VoiceCount; v++) begin
        voice_gain_q[v] <= Unity;
      end
      trem_gain_q <= Unity;
      phase_q     <= '0;
    end else if (state_q == ST_GAIN) begin
      voice_gain_q <= voice_gain_d;
      trem_gain_q  <= trem_gain_d;
      phase_q      <= phase_d;
    end
  end

  // voice lanes
  for (genvar v = 0; v < VoiceCount; v++) begin : g_voice
    vmeg_voice_lane u_voice (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (state_q == ST_SCALE),
      .clear_i (frame_q.block_start),
      .voice_i (voice_in[v]),
      .gain_i  (voice_gain_q[v]),
      .held_o  (held[v])
    );
  end

  vmeg_mix u_mix (
    .held_i      (held),
    .trem_gain_i (trem_gain_q),
    .mix_o       (mix_value)
  );

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (state_q == ST_MIX && out_free) begin
        out_q.mix_sample <= mix_value;
        out_valid_q      <= 1'b1;
      end else if (mix_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (frame_i.valid) begin
            state_q <= ST_GAIN;
          end
        end
        ST_GAIN:  state_q <= ST_SCALE;
        ST_SCALE: state_q <= ST_MIX;
        ST_MIX: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/vmeg_checker.sv */
// vmeg_checker: port-level assertions for voice_mixer_envelope_gain
// bound to the top level; depends on vmeg_pkg
`timescale 1ns / 1ps
`default_nettype none

module vmeg_checker
  import vmeg_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_ready_i,
  input logic    out_valid_i,
  input logic    out_ready_i,
  input sample_t out_sample_i
);

  // a beat waiting at the output stays until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_sample_i))
    else $error("output sample changed while stalled");

  // one frame in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("frame taken while another is in flight");

  // output valid is checked once every accepted frame has passed gain, scaling and mixing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> ##4 out_valid_i)
    else $error("result missing four cycles after frame beat");

endmodule

bind voice_mixer_envelope_gain vmeg_checker u_vmeg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (frame_i.valid),
  .in_ready_i   (frame_i.ready),
  .out_valid_i  (mix_o.valid),
  .out_ready_i  (mix_o.ready),
  .out_sample_i (mix_o.payload.mix_sample)
);

`default_nettype wire
